[design/icmr_pkg.sv]
// shared types, constants and helpers for the int8 conv mac with requantization
// depends on nothing; imported by every module of the block

package icmr_pkg;

	// default accumulator width and widest supported accumulator
	localparam int AccWidthDef = 32;
	localparam int AccWidthMax = 48;

	// default depth of the point queue between front and back
	localparam int QueueDepthDef = 4;

	// width of the result value, signed q31.16
	localparam int ValueW = 48;

	// configuration register indexes
	localparam int CfgIdxW = 4;
	localparam logic [CfgIdxW-1:0] REG_OUTPUT_SCALE   = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] REG_REQUANT_ENABLE = CfgIdxW'(1);
	localparam logic [CfgIdxW-1:0] REG_RELU_ENABLE    = CfgIdxW'(2);
	localparam logic [CfgIdxW-1:0] REG_BIAS_ENABLE    = CfgIdxW'(3);

	// reset value of the output scale, 1.0 in q8.24
	localparam logic [31:0] OutputScaleReset = 32'h0100_0000;

	// dequantization magnitude cap (2^47) and the early-out bound on the high product
	localparam logic [63:0] DqCap    = 64'h0000_8000_0000_0000;
	localparam logic [63:0] DqHiCap  = 64'h0000_0080_0000_0000;
	// requantization early-out bound, rounding half and int8 clamp
	localparam logic [63:0] RqHiCap  = 64'h0000_0000_8000_0000;
	localparam logic [63:0] RqHalf   = 64'h0000_0080_0000_0000;
	localparam logic [6:0]  Int8Max  = 7'd127;

	// signed 48-bit limits
	localparam logic signed [ValueW-1:0] V48Max = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [ValueW-1:0] V48Min = 48'sh8000_0000_0000;

	// configuration seen by the back end
	typedef struct packed {
		logic [31:0] output_scale;
		logic        requant_enable;
		logic        relu_enable;
		logic        bias_enable;
	} cfg_t;

	// one finished point handed from front to back
	typedef struct packed {
		logic signed [ValueW-1:0] sum;
		logic [31:0]              mult;
		logic signed [31:0]       bias;
	} point_t;

	// saturate a 49-bit signed value to 48 bits
	function automatic logic signed [ValueW-1:0] sat48(input logic signed [ValueW:0] v);
		logic signed [ValueW-1:0] r;
		if (v > ValueW'(V48Max) && v[ValueW] == 1'b0 && v[ValueW-1] == 1'b1) begin
			r = V48Max;
		end else if (v[ValueW] == 1'b1 && v[ValueW-1] == 1'b0) begin
			r = V48Min;
		end else begin
			r = v[ValueW-1:0];
		end
		return r;
	endfunction

endpackage

[design/icmr_front.sv]
// front end: accepts activation/weight pairs and accumulates them
// depends on icmr_pkg; hands a point_t to the queue on the last pair

module icmr_front import icmr_pkg::*; #(
	parameter int ACC_WIDTH = AccWidthDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic signed [7:0] activation,
	input  logic signed [7:0] weight,
	input  logic              first,
	input  logic              last,
	input  logic [31:0]       dequant_mult,
	input  logic signed [31:0] bias,
	output logic              q_push,
	output point_t            q_data
);

	logic signed [ACC_WIDTH-1:0] acc_q;
	logic signed [ACC_WIDTH-1:0] acc_next;
	logic signed [15:0]          prod;

	// one 8x8 product and wrapping add per word
	assign prod     = activation * weight;
	assign acc_next = first ? ACC_WIDTH'(prod) : acc_q + ACC_WIDTH'(prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (accept) begin
			acc_q <= acc_next;
		end
	end

	// finished point goes to the queue with its channel data
	assign q_push      = accept && last;
	assign q_data.sum  = ValueW'(acc_next);
	assign q_data.mult = dequant_mult;
	assign q_data.bias = bias;

endmodule

[design/icmr_fifo.sv]
// small queue of finished points between front and back
// depends on icmr_pkg for point_t

module icmr_fifo import icmr_pkg::*; #(
	parameter int DEPTH = QueueDepthDef
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  point_t wr_data,
	input  logic   rd_en,
	output point_t rd_data,
	output logic   q_full,
	output logic   q_empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	point_t            entry_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
	endfunction

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CntW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data = entry_q[rd_ptr_q];
	assign q_full  = (count_q == CntW'(DEPTH));
	assign q_empty = (count_q == '0);

endmodule

[design/icmr_back.sv]
// back end: dequantize, bias, requantize and relu one point at a time
// depends on icmr_pkg; one shared 48x16 multiplier, result held in an output register

module icmr_back import icmr_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      in_valid,
	input  point_t                    in_data,
	output logic                      in_pop,
	output logic                      empty,
	input  logic                      pop,
	output logic signed [ValueW-1:0]  value
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DQ_HI,
		S_DQ_LO,
		S_DQ_SUM,
		S_BIAS,
		S_ABS,
		S_RQ_HI,
		S_RQ_LO,
		S_RQ_SUM,
		S_OUT
	} state_t;

	state_t                   state_q;
	logic                     out_valid_q;
	logic signed [ValueW-1:0] value_q;
	logic [ValueW-1:0]        mag_q;
	logic                     neg_q;
	logic [31:0]              mult_q;
	logic signed [31:0]       bias_q;
	logic [63:0]              a_q;
	logic [63:0]              b_q;
	logic signed [ValueW-1:0] v_q;
	logic signed [ValueW-1:0] res_q;

	logic [15:0]              mul_b;
	logic [63:0]              mul_p;
	logic [63:0]              dq_r;
	logic [ValueW-1:0]        dq_mag;
	logic signed [ValueW:0]   dq_v;
	logic signed [ValueW:0]   bias_sum;
	logic [63:0]              rq_t;
	logic [63:0]              rq_q64;
	logic [6:0]               rq_q;
	logic signed [7:0]        rq_r;
	logic signed [ValueW-1:0] plain_res;
	logic                     out_free;
	logic                     out_load;

	// shared multiplier, operand picked by step
	always_comb begin
		case (state_q)
			S_DQ_HI: mul_b = mult_q[31:16];
			S_DQ_LO: mul_b = mult_q[15:0];
			S_RQ_HI: mul_b = cfg.output_scale[31:16];
			S_RQ_LO: mul_b = cfg.output_scale[15:0];
			default: mul_b = '0;
		endcase
	end
	assign mul_p = mag_q * mul_b;

	// dequantized magnitude, truncated to q31.16 and capped at 2^47
	always_comb begin
		dq_r = (a_q << 8) + (b_q >> 8);
		if (a_q > DqHiCap || dq_r > DqCap) begin
			dq_mag = DqCap[ValueW-1:0];
		end else begin
			dq_mag = dq_r[ValueW-1:0];
		end
		dq_v = neg_q ? -$signed({1'b0, dq_mag}) : $signed({1'b0, dq_mag});
	end

	// bias add on 49 bits
	assign bias_sum = (ValueW + 1)'(v_q) + (cfg.bias_enable ? (ValueW + 1)'(bias_q) : '0);

	// requantized magnitude, round half away from zero, clamp to 127
	always_comb begin
		rq_t   = (a_q << 16) + b_q;
		rq_q64 = (rq_t + RqHalf) >> 40;
		if (a_q >= RqHiCap || rq_q64 > 64'(Int8Max)) begin
			rq_q = Int8Max;
		end else begin
			rq_q = rq_q64[6:0];
		end
		if (neg_q) begin
			rq_r = cfg.relu_enable ? 8'sd0 : -$signed({1'b0, rq_q});
		end else begin
			rq_r = $signed({1'b0, rq_q});
		end
	end

	// dequantized result with optional relu
	assign plain_res = (cfg.relu_enable && v_q[ValueW-1]) ? '0 : v_q;

	assign out_free = !out_valid_q || pop;
	assign out_load = (state_q == S_OUT) && out_free;
	assign in_pop   = (state_q == S_IDLE) && in_valid;

	// sequencer, working registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			mult_q      <= '0;
			bias_q      <= '0;
			a_q         <= '0;
			b_q         <= '0;
			v_q         <= '0;
			res_q       <= '0;
		end else begin
			// output word valid: set on load, cleared on pop
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						neg_q   <= in_data.sum[ValueW-1];
						mag_q   <= in_data.sum[ValueW-1] ? -in_data.sum : in_data.sum;
						mult_q  <= in_data.mult;
						bias_q  <= in_data.bias;
						state_q <= S_DQ_HI;
					end
				end
				S_DQ_HI: begin
					a_q     <= mul_p;
					state_q <= S_DQ_LO;
				end
				S_DQ_LO: begin
					b_q     <= mul_p;
					state_q <= S_DQ_SUM;
				end
				S_DQ_SUM: begin
					v_q     <= sat48(dq_v);
					state_q <= S_BIAS;
				end
				S_BIAS: begin
					v_q     <= sat48(bias_sum);
					state_q <= cfg.requant_enable ? S_ABS : S_OUT;
				end
				S_ABS: begin
					neg_q   <= v_q[ValueW-1];
					mag_q   <= v_q[ValueW-1] ? -v_q : v_q;
					state_q <= S_RQ_HI;
				end
				S_RQ_HI: begin
					a_q     <= mul_p;
					state_q <= S_RQ_LO;
				end
				S_RQ_LO: begin
					b_q     <= mul_p;
					state_q <= S_RQ_SUM;
				end
				S_RQ_SUM: begin
					res_q   <= ValueW'(rq_r);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						value_q <= cfg.requant_enable ? res_q : plain_res;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign empty = !out_valid_q;
	assign value = value_q;

endmodule

[design/int8_conv_mac_requantize.sv]
// top level of the int8 convolution mac with requantization
// depends on icmr_pkg, icmr_front, icmr_fifo and icmr_back
//
// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------
// input     | push / full          | activation, weight, first, last,
//           |                      | dequant_mult, bias
// result    | empty / pop          | value
// config    | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// the front takes one activation/weight word each cycle while full is low; the 8x8
// multiply and wrapping add finish in the cycle the word is taken.
// a last word queues its point; the back finishes each point before taking the next
// and uses its one shared 48x16 multiplier twice, four times when requantizing.
// full rises only when the point queue holds QUEUE_DEPTH points; a waiting result
// in the output register does not stop the front.
// reset is asynchronous and leaves accumulator, queue and output empty.

module int8_conv_mac_requantize import icmr_pkg::*; #(
	parameter int ACC_WIDTH   = AccWidthDef,
	parameter int QUEUE_DEPTH = QueueDepthDef
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic signed [7:0]        activation,
	input  logic signed [7:0]        weight,
	input  logic                     first,
	input  logic                     last,
	input  logic [31:0]              dequant_mult,
	input  logic signed [31:0]       bias,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [ValueW-1:0] value,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CfgIdxW-1:0]       cfg_index,
	input  logic [31:0]              cfg_data
);

	cfg_t   cfg_q;
	logic   accept;
	logic   q_push;
	logic   q_pop;
	logic   q_full;
	logic   q_empty;
	point_t q_wdata;
	point_t q_rdata;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.output_scale   <= OutputScaleReset;
			cfg_q.requant_enable <= 1'b0;
			cfg_q.relu_enable    <= 1'b0;
			cfg_q.bias_enable    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OUTPUT_SCALE:   cfg_q.output_scale   <= cfg_data;
				REG_REQUANT_ENABLE: cfg_q.requant_enable <= cfg_data[0];
				REG_RELU_ENABLE:    cfg_q.relu_enable    <= cfg_data[0];
				REG_BIAS_ENABLE:    cfg_q.bias_enable    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input word acceptance
	assign full   = q_full;
	assign accept = push && !q_full;

	icmr_front #(
		.ACC_WIDTH(ACC_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.activation   (activation),
		.weight       (weight),
		.first        (first),
		.last         (last),
		.dequant_mult (dequant_mult),
		.bias         (bias),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	icmr_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	icmr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (!q_empty),
		.in_data  (q_rdata),
		.in_pop   (q_pop),
		.empty    (empty),
		.pop      (pop),
		.value    (value)
	);

`ifndef NO_ASSERTIONS
	// the back end never takes a point from an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("point queue read while empty");

	// a last word is never queued while the queue is full
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("point queue written while full");

	// a queue that was full and saw no read stays full
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_full && !q_pop) |=> q_full)
		else $error("point queue lost an entry");
`endif

endmodule

[test/tb_int8_conv_mac_requantize.sv]
// self-checking testbench for int8_conv_mac_requantize: mac words in, results out
// depends on icmr_pkg and the block's rtl; predicts each result from its own model

module tb_int8_conv_mac_requantize import icmr_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AccW        = AccWidthDef;
	localparam int CycleLimit  = 200_000;
	localparam int HoldCycles  = 300;
	localparam int DrainCycles = 40;
	localparam int MaxReports  = 10;
	localparam int IdlePct     = 32;
	localparam int PhaseWords  = 135;
	localparam int SatWords    = 600;
	// index outside the register map, written once and expected to change nothing
	localparam logic [CfgIdxW-1:0] RegSpare = CfgIdxW'(13);
	localparam logic [31:0] ScaleOne = 32'h0100_0000;
	localparam logic [31:0] MultMax  = 32'hFFFF_FFFF;

	// one input word of the mac stream
	typedef struct packed {
		logic signed [7:0]  activation;
		logic signed [7:0]  weight;
		logic               first;
		logic               last;
		logic [31:0]        dequant_mult;
		logic signed [31:0] bias;
	} mac_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	mac_word_t offered_word = '0;

	logic full, empty, cfg_ready;
	logic signed [7:0] activation, weight;
	logic first, last;
	logic [31:0] dequant_mult;
	logic signed [31:0] bias;
	logic signed [ValueW-1:0] value;

	// shadow registers and accumulator of the prediction
	logic [31:0] sh_scale = OutputScaleReset;
	logic sh_requant = 1'b0;
	logic sh_relu = 1'b0;
	logic sh_bias_en = 1'b0;
	logic signed [AccW-1:0] acc_model = '0;

	mac_word_t pending_words[$];
	logic signed [ValueW-1:0] expected_values[$];
	int words_queued = 0;
	int words_taken = 0;
	int cfg_writes = 0;
	int mismatches = 0;
	int send_idle_pct = IdlePct;
	int recv_idle_pct = IdlePct;
	bit in_taken = 1'b0;
	bit rx_hold = 1'b0;
	event hold_kick;

	assign activation   = offered_word.activation;
	assign weight       = offered_word.weight;
	assign first        = offered_word.first;
	assign last         = offered_word.last;
	assign dequant_mult = offered_word.dequant_mult;
	assign bias         = offered_word.bias;

	int8_conv_mac_requantize u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.activation   (activation),
		.weight       (weight),
		.first        (first),
		.last         (last),
		.dequant_mult (dequant_mult),
		.bias         (bias),
		.empty        (empty),
		.pop          (pop),
		.value        (value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial forever #4 clk = ~clk;

	// clamp to the signed 48-bit range
	function automatic longint clamp48(input longint v);
		if (v > longint'(V48Max)) return longint'(V48Max);
		if (v < longint'(V48Min)) return longint'(V48Min);
		return v;
	endfunction

	// value of a finished point under the current register settings
	function automatic logic signed [ValueW-1:0] point_value(
			input logic signed [AccW-1:0] sum, input logic [31:0] mult,
			input logic signed [31:0] bias_q16);
		longint sum_l, v;
		logic [63:0] mag, dq, vm;
		logic [95:0] q;
		sum_l = longint'(sum);
		mag = (sum_l < 0) ? 64'(-sum_l) : 64'(sum_l);
		// integer times q8.24 down to q.16, magnitude truncated, capped at 2^47
		dq = (mag * {32'd0, mult}) >> 8;
		if (dq > DqCap) dq = DqCap;
		v = (sum_l < 0) ? -longint'(dq) : longint'(dq);
		v = clamp48(v);
		if (sh_bias_en) v = clamp48(v + longint'(bias_q16));
		// q.16 times q8.24 is q.40, rounded half away from zero
		if (sh_requant) begin
			vm = (v < 0) ? 64'(-v) : 64'(v);
			q = ({32'd0, vm} * {64'd0, sh_scale} + (96'd1 << 39)) >> 40;
			if (q > 96'(Int8Max)) q = 96'(Int8Max);
			v = (v < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
		end
		if (sh_relu && v < 0) v = 0;
		return v[ValueW-1:0];
	endfunction

	// sampling at the rising edge: words in, results out, register writes
	always @(posedge clk) begin
		logic signed [15:0] tap_product;
		logic signed [ValueW-1:0] want;
		if (arst_n) begin
			in_taken = push && !full;
			if (in_taken) begin
				tap_product = offered_word.activation * offered_word.weight;
				acc_model = offered_word.first ? AccW'(tap_product)
					: acc_model + AccW'(tap_product);
				if (offered_word.last)
					expected_values.push_back(point_value(acc_model,
						offered_word.dequant_mult, offered_word.bias));
				words_taken++;
			end
			if (pop && !empty) begin
				if (expected_values.size() == 0) begin
					mismatches++;
					if (mismatches <= MaxReports)
						$display("%0t: result %0d with none expected", $time, value);
				end else begin
					want = expected_values.pop_front();
					if (value !== want) begin
						mismatches++;
						if (mismatches <= MaxReports)
							$display("%0t: value expected %0d (%h) got %0d (%h)",
								$time, want, want, value, value);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_OUTPUT_SCALE:   sh_scale = cfg_data;
					REG_REQUANT_ENABLE: sh_requant = cfg_data[0];
					REG_RELU_ENABLE:    sh_relu = cfg_data[0];
					REG_BIAS_ENABLE:    sh_bias_en = cfg_data[0];
					default: ;
				endcase
				cfg_writes++;
			end
		end
	end

	// sender: next word once the current one is taken, with random gaps
	always @(negedge clk) begin
		if (arst_n && (!push || in_taken)) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				offered_word <= pending_words.pop_front();
				push <= 1'b1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver: random pops, none during a hold
	always @(negedge clk) begin
		if (arst_n) pop <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	// long receiver hold so the point queue fills and full rises
	always begin
		@(hold_kick);
		rx_hold = 1'b1;
		repeat (HoldCycles) @(posedge clk);
		rx_hold = 1'b0;
	end

	// cycle limit
	initial begin
		for (int n = 0; n < CycleLimit; n++) @(posedge clk);
		$display("int8_conv_mac_requantize regression: fail");
		$finish;
	end

	task automatic queue_word(input logic signed [7:0] a, input logic signed [7:0] w,
			input logic f, input logic l, input logic [31:0] mult,
			input logic signed [31:0] b);
		mac_word_t word;
		word = '{activation: a, weight: w, first: f, last: l, dequant_mult: mult, bias: b};
		pending_words.push_back(word);
		words_queued++;
	endtask

	// block is idle: every word taken, every result out, back end drained
	task automatic wait_idle();
		@(negedge clk);
		while (words_taken != words_queued || expected_values.size() != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
		int seen;
		seen = cfg_writes;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (cfg_writes == seen);
		cfg_valid <= 1'b0;
	endtask

	// enables go out with random upper bits, only bit 0 counts
	task automatic apply_settings(input logic [31:0] scale, input logic rq,
			input logic relu, input logic bias_en);
		wait_idle();
		write_reg(REG_OUTPUT_SCALE, scale);
		write_reg(REG_REQUANT_ENABLE, ($urandom() & ~32'd1) | 32'(rq));
		write_reg(REG_RELU_ENABLE, ($urandom() & ~32'd1) | 32'(relu));
		write_reg(REG_BIAS_ENABLE, ($urandom() & ~32'd1) | 32'(bias_en));
	endtask

	function automatic logic signed [7:0] rand_tap();
		logic signed [7:0] r;
		r = $urandom();
		if ($urandom_range(0, 4) == 0) begin
			case ($urandom_range(0, 3))
				0: r = -8'sd128;
				1: r = 8'sd127;
				2: r = 8'sd0;
				default: r = -8'sd1;
			endcase
		end
		return r;
	endfunction

	// mostly multipliers that keep int8 results in range, some extremes
	function automatic logic [31:0] rand_mult();
		logic [31:0] r;
		case ($urandom_range(0, 9))
			0: r = '0;
			1: r = MultMax;
			2: r = $urandom();
			3, 4, 5: r = $urandom_range(0, 1 << 18);
			default: r = $urandom_range(0, 1 << 24);
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] rand_bias();
		logic signed [31:0] r;
		case ($urandom_range(0, 9))
			0: r = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			1, 2: r = $urandom();
			default: r = $urandom_range(0, 1 << 24) - (1 << 23);
		endcase
		return r;
	endfunction

	// one point: mostly well formed, some continuing the last sum, some with scrambled flags
	task automatic queue_random_point();
		int len, shape;
		logic f, l;
		shape = $urandom_range(0, 9);
		case ($urandom_range(0, 9))
			0, 1: len = 1;
			2: len = $urandom_range(7, 32);
			default: len = $urandom_range(2, 6);
		endcase
		for (int i = 0; i < len; i++) begin
			f = (i == 0);
			l = (i == len - 1);
			if (shape == 0) begin
				f = 1'b0;
			end else if (shape == 1) begin
				f = $urandom_range(0, 1);
				l = $urandom_range(0, 1);
			end
			queue_word(rand_tap(), rand_tap(), f, l, rand_mult(), rand_bias());
		end
	endtask

	task automatic fill_random(input int n);
		int goal;
		goal = words_queued + n;
		while (words_queued < goal) queue_random_point();
	endtask

	// main sequence
	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: dequantized output, bias ignored
		queue_word(8'sd127, 8'sd127, 1'b1, 1'b1, ScaleOne, 32'sd0);
		queue_word(-8'sd128, -8'sd128, 1'b1, 1'b1, MultMax, 32'sh7FFF_FFFF);
		queue_word(-8'sd128, 8'sd127, 1'b1, 1'b1, MultMax, 32'sh8000_0000);
		// zero multiplier
		queue_word(8'sd100, -8'sd3, 1'b1, 1'b1, 32'd0, 32'sd0);
		// truncation toward zero of small negative sums
		queue_word(-8'sd1, 8'sd1, 1'b1, 1'b1, 32'h0000_0080, 32'sd0);
		queue_word(-8'sd3, 8'sd1, 1'b1, 1'b1, 32'h0000_01FF, 32'sd0);
		// a three-word point, then a restart in the middle of a point
		queue_word(8'sd5, 8'sd6, 1'b1, 1'b0, $urandom(), $urandom());
		queue_word(-8'sd7, 8'sd8, 1'b0, 1'b0, $urandom(), $urandom());
		queue_word(8'sd9, 8'sd9, 1'b0, 1'b1, ScaleOne, 32'sd0);
		queue_word(8'sd50, 8'sd50, 1'b1, 1'b0, $urandom(), $urandom());
		queue_word(8'sd1, 8'sd1, 1'b1, 1'b1, ScaleOne, 32'sd0);

		// requantization: rounding of halves, clamp at both ends, bias only
		apply_settings(ScaleOne, 1'b1, 1'b0, 1'b1);
		queue_word(8'sd0, 8'sd0, 1'b1, 1'b1, 32'd0, 32'sh0000_8000);
		queue_word(8'sd0, 8'sd0, 1'b1, 1'b1, 32'd0, -32'sh0000_8000);
		queue_word(8'sd0, 8'sd0, 1'b1, 1'b1, 32'd0, 32'sh0000_7FFF);
		queue_word(8'sd127, 8'sd127, 1'b1, 1'b1, ScaleOne, 32'sd0);
		queue_word(-8'sd128, 8'sd127, 1'b1, 1'b1, ScaleOne, 32'sd0);
		queue_word(8'sd10, 8'sd10, 1'b1, 1'b1, ScaleOne, 32'sh0001_0000);
		queue_word(8'sd0, 8'sd0, 1'b1, 1'b1, MultMax, 32'sh8000_0000);

		// largest scale with relu
		apply_settings(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
		queue_word(-8'sd5, 8'sd5, 1'b1, 1'b1, ScaleOne, 32'sd0);
		queue_word(8'sd1, 8'sd1, 1'b1, 1'b1, 32'h0001_0000, 32'sd0);
		queue_word(8'sd127, 8'sd127, 1'b1, 1'b1, ScaleOne, 32'sd0);

		// zero scale, dequantized path with relu and bias
		apply_settings(32'd0, 1'b0, 1'b1, 1'b1);
		queue_word(-8'sd128, -8'sd128, 1'b1, 1'b1, MultMax, -32'sd1);
		queue_word(-8'sd100, 8'sd100, 1'b1, 1'b1, ScaleOne, 32'sd5);
		wait_idle();
		write_reg(RegSpare, $urandom());

		// random phases over several settings
		apply_settings(ScaleOne, 1'b1, 1'b0, 1'b1);
		fill_random(PhaseWords);
		apply_settings(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
		fill_random(PhaseWords);
		apply_settings(32'd0, 1'b1, 1'b0, 1'b1);
		fill_random(PhaseWords);
		apply_settings($urandom(), 1'b0, 1'b1, 1'b1);
		fill_random(PhaseWords);
		apply_settings(32'h0010_0000, 1'b1, 1'b1, 1'b1);
		fill_random(PhaseWords);
		-> hold_kick;
		apply_settings($urandom(), 1'b0, 1'b0, 1'b0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		fill_random(PhaseWords);
		apply_settings(32'h0400_0000, 1'b1, 1'b0, 1'b0);
		send_idle_pct = IdlePct;
		recv_idle_pct = IdlePct;
		fill_random(PhaseWords);
		apply_settings(ScaleOne, 1'b0, 1'b0, 1'b1);
		fill_random(PhaseWords);

		// long point: positive saturation before and after the bias
		for (int i = 0; i < SatWords; i++)
			queue_word(8'sd127, 8'sd127, i == 0, i == SatWords - 1, MultMax,
				32'sh7FFF_FFFF);

		wait_idle();
		if (mismatches == 0) begin
			$display("int8_conv_mac_requantize regression: pass");
		end else begin
			$display("int8_conv_mac_requantize regression: fail");
		end
		$finish;
	end

endmodule
